[hdl/mwf_pkg.sv]
// mwf_pkg: shared types, constants and helper functions of the maze wall follower
// used by mwf_nbr_unit and maze_wall_follower_core; no dependencies
`timescale 1ns / 1ps

package mwf_pkg;

  // grid storage size
  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 64;
  localparam int CELLS      = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W     = $clog2(CELLS);

  // field widths
  localparam int POS_W      = 6;
  localparam int CNT_W      = 7;
  localparam int HEAD_W     = 2;
  localparam int REQ_W      = 2;
  localparam int PROBE_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [HEAD_W-1:0]  head_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [PROBE_W-1:0] probe_t;

  // request kinds
  localparam logic [REQ_W-1:0] REQ_LOAD = 2'd0;
  localparam logic [REQ_W-1:0] REQ_STEP = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

  // headings
  localparam head_t HEAD_NORTH = 2'd0;
  localparam head_t HEAD_EAST  = 2'd1;
  localparam head_t HEAD_SOUTH = 2'd2;
  localparam head_t HEAD_WEST  = 2'd3;

  // relative turns
  localparam head_t TURN_RIGHT = 2'd1;
  localparam head_t TURN_NONE  = 2'd0;
  localparam head_t TURN_LEFT  = 2'd3;
  localparam head_t TURN_BACK  = 2'd2;

  // probe order: right, straight, left
  localparam probe_t PROBE_RIGHT    = 2'd0;
  localparam probe_t PROBE_STRAIGHT = 2'd1;
  localparam probe_t PROBE_LEFT     = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ROW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_COL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_ROW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_COL  = 3'd5;

  // neighbour probe request and answer
  typedef struct packed {
    pos_t   row;
    pos_t   col;
    head_t  heading;
    probe_t probe;
    cnt_t   rows;
    cnt_t   cols;
  } nbr_req_t;

  typedef struct packed {
    pos_t  row;
    pos_t  col;
    head_t heading;
    logic  in_grid;
  } nbr_rsp_t;

  // zero acts as one, larger than storage saturates
  function automatic cnt_t eff_count(cnt_t c, cnt_t max_c);
    cnt_t r;
    if (c == '0) begin
      r = cnt_t'(1);
    end else if (c > max_c) begin
      r = max_c;
    end else begin
      r = c;
    end
    return r;
  endfunction

  // linear cell address, row major
  function automatic addr_t cell_addr(pos_t r, pos_t c);
    return addr_t'(r) * addr_t'(MAX_COLS) + addr_t'(c);
  endfunction

  // turn applied for each probe
  function automatic head_t probe_turn(probe_t k);
    head_t t;
    case (k)
      PROBE_RIGHT:    t = TURN_RIGHT;
      PROBE_STRAIGHT: t = TURN_NONE;
      default:        t = TURN_LEFT;
    endcase
    return t;
  endfunction

endpackage

[hdl/mwf_nbr_unit.sv]
// mwf_nbr_unit: shared neighbour unit, one probe direction per use
// gives the neighbour cell, its heading and whether it lies inside the grid
// depends on mwf_pkg
`timescale 1ns / 1ps

module mwf_nbr_unit (
  input  mwf_pkg::nbr_req_t req,
  output mwf_pkg::nbr_rsp_t rsp
);
  import mwf_pkg::*;

  head_t h;
  cnt_t  row_ext;
  cnt_t  col_ext;
  cnt_t  row_n;
  cnt_t  col_n;
  logic  row_ok;
  logic  col_ok;

  // heading of this probe
  assign h       = req.heading + probe_turn(req.probe);
  assign row_ext = {1'b0, req.row};
  assign col_ext = {1'b0, req.col};

  // one step in the probe direction with border checks
  always_comb begin
    row_n  = row_ext;
    col_n  = col_ext;
    row_ok = row_ext < req.rows;
    col_ok = col_ext < req.cols;
    case (h)
      HEAD_NORTH: begin
        row_n  = row_ext - cnt_t'(1);
        row_ok = (row_ext != '0) && (row_n < req.rows);
      end
      HEAD_SOUTH: begin
        row_n  = row_ext + cnt_t'(1);
        row_ok = row_n < req.rows;
      end
      HEAD_EAST: begin
        col_n  = col_ext + cnt_t'(1);
        col_ok = col_n < req.cols;
      end
      default: begin
        col_n  = col_ext - cnt_t'(1);
        col_ok = (col_ext != '0) && (col_n < req.cols);
      end
    endcase
  end

  assign rsp.row     = row_n[POS_W-1:0];
  assign rsp.col     = col_n[POS_W-1:0];
  assign rsp.heading = h;
  assign rsp.in_grid = row_ok && col_ok;

endmodule

[hdl/maze_wall_follower_core.sv]
// Load, unknown and first step need no probe; a read first captures the memory output.
// Later steps off the goal probe up to three neighbours, each in-grid probe reading a wall.
// One item at a time: the next item is taken once the result is in the output register;
// the wall memory read port, shared by all probes through one neighbour unit, sets this.
// Reset (rst_n low, synchronous) clears control state, then every cell of the visited map
// is swept to zero before the first input is taken.
// depends on mwf_pkg and mwf_nbr_unit
`timescale 1ns / 1ps

module maze_wall_follower_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: cell_row[5:0], cell_col[11:6], is_wall[12], zero [15:13]
  input  logic [mwf_pkg::IN_DATA_W-1:0]       in_tdata,
  // in_tuser: req_type[1:0]
  input  logic [mwf_pkg::REQ_W-1:0]           in_tuser,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // out_tdata: pos_row[5:0], pos_col[11:6], heading[13:12], arrived[14],
  // read_wall[15], read_visited[16], zero [23:17]
  output logic [mwf_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [mwf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mwf_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready
);
  import mwf_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RDCAP,
    S_PROBE,
    S_PWAIT,
    S_DONE
  } state_t;

  localparam addr_t LAST_ADDR = addr_t'(CELLS - 1);
  localparam cnt_t  ROWS_MAX  = cnt_t'(MAX_ROWS);
  localparam cnt_t  COLS_MAX  = cnt_t'(MAX_COLS);

  state_t state_r, state_nxt;
  addr_t  clr_addr_r, clr_addr_nxt;
  probe_t k_r, k_nxt;
  pos_t   walker_row_r, walker_row_nxt;
  pos_t   walker_col_r, walker_col_nxt;
  head_t  walker_head_r, walker_head_nxt;
  logic   started_r, started_nxt;
  pos_t   cand_row_r, cand_row_nxt;
  pos_t   cand_col_r, cand_col_nxt;
  head_t  cand_head_r, cand_head_nxt;
  logic   in_store_r, in_store_nxt;
  logic   rw_r, rw_nxt;
  logic   rv_r, rv_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  cnt_t   rows_r, cols_r;
  pos_t   start_row_r, start_col_r, goal_row_r, goal_col_r;

  // memories
  logic   wall_mem [CELLS];
  logic   vis_mem  [CELLS];
  logic   wall_q_r;
  logic   vis_q_r;
  addr_t  rd_addr;
  logic   wall_we;
  addr_t  wall_waddr;
  logic   vis_we;
  addr_t  vis_waddr;
  logic   vis_wdata;

  // input fields
  logic [REQ_W-1:0] in_req;
  pos_t   in_row;
  pos_t   in_col;
  logic   in_wall;
  logic   in_accept;
  logic   in_fits;
  addr_t  in_addr;

  // walker placement and goal check
  pos_t   place_row;
  pos_t   place_col;
  head_t  place_head;
  logic   at_goal;

  nbr_req_t nbr_req;
  nbr_rsp_t nbr_rsp;

  assign in_req  = in_tuser;
  assign in_row  = in_tdata[POS_W-1:0];
  assign in_col  = in_tdata[2*POS_W-1:POS_W];
  assign in_wall = in_tdata[2*POS_W];

  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign in_fits   = ({1'b0, in_row} < ROWS_MAX) && ({1'b0, in_col} < COLS_MAX);
  assign in_addr   = cell_addr(in_row, in_col);

  assign cfg_ready  = 1'b1;
  assign out_tdata  = out_data_r;
  assign out_tvalid = out_valid_r;

  // configuration registers, counts kept in their effective form
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r      <= ROWS_MAX;
      cols_r      <= COLS_MAX;
      start_row_r <= '0;
      start_col_r <= '0;
      goal_row_r  <= '0;
      goal_col_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROW_COUNT: rows_r      <= eff_count(cfg_data, ROWS_MAX);
        CFG_COL_COUNT: cols_r      <= eff_count(cfg_data, COLS_MAX);
        CFG_START_ROW: start_row_r <= cfg_data[POS_W-1:0];
        CFG_START_COL: start_col_r <= cfg_data[POS_W-1:0];
        CFG_GOAL_ROW:  goal_row_r  <= cfg_data[POS_W-1:0];
        CFG_GOAL_COL:  goal_col_r  <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // start cell clamped into the grid, heading from its border
  always_comb begin
    place_row = ({1'b0, start_row_r} < rows_r) ? start_row_r
                                                : POS_W'(rows_r - cnt_t'(1));
    place_col = ({1'b0, start_col_r} < cols_r) ? start_col_r
                                                : POS_W'(cols_r - cnt_t'(1));
    if (place_row == '0) begin
      place_head = HEAD_SOUTH;
    end else if ({1'b0, place_row} == rows_r - cnt_t'(1)) begin
      place_head = HEAD_NORTH;
    end else if (place_col == '0) begin
      place_head = HEAD_EAST;
    end else begin
      place_head = HEAD_WEST;
    end
  end

  assign at_goal = (walker_row_r == goal_row_r) && (walker_col_r == goal_col_r);

  // shared neighbour unit
  assign nbr_req.row     = walker_row_r;
  assign nbr_req.col     = walker_col_r;
  assign nbr_req.heading = walker_head_r;
  assign nbr_req.probe   = k_r;
  assign nbr_req.rows    = rows_r;
  assign nbr_req.cols    = cols_r;

  mwf_nbr_unit u_nbr (
    .req (nbr_req),
    .rsp (nbr_rsp)
  );

  // memory port control
  always_comb begin
    rd_addr    = (state_r == S_PROBE) ? cell_addr(nbr_rsp.row, nbr_rsp.col) : in_addr;
    wall_we    = in_accept && (in_req == REQ_LOAD) && in_fits;
    wall_waddr = in_addr;
    vis_we     = 1'b0;
    vis_waddr  = clr_addr_r;
    vis_wdata  = 1'b0;
    if (state_r == S_CLEAR) begin
      vis_we = 1'b1;
    end else if (in_accept && (in_req == REQ_STEP) && started_r) begin
      vis_we    = 1'b1;
      vis_waddr = cell_addr(walker_row_r, walker_col_r);
      vis_wdata = 1'b1;
    end
  end

  // wall map
  always_ff @(posedge clk) begin
    if (wall_we) begin
      wall_mem[wall_waddr] <= in_wall;
    end
    wall_q_r <= wall_mem[rd_addr];
  end

  // visited map
  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_waddr] <= vis_wdata;
    end
    vis_q_r <= vis_mem[rd_addr];
  end

  // sequencer next state
  always_comb begin
    state_nxt       = state_r;
    clr_addr_nxt    = clr_addr_r;
    k_nxt           = k_r;
    walker_row_nxt  = walker_row_r;
    walker_col_nxt  = walker_col_r;
    walker_head_nxt = walker_head_r;
    started_nxt     = started_r;
    cand_row_nxt    = cand_row_r;
    cand_col_nxt    = cand_col_r;
    cand_head_nxt   = cand_head_r;
    in_store_nxt    = in_store_r;
    rw_nxt          = rw_r;
    rv_nxt          = rv_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_data_nxt    = out_data_r;

    case (state_r)
      S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + addr_t'(1);
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_accept) begin
          rw_nxt       = 1'b0;
          rv_nxt       = 1'b0;
          in_store_nxt = in_fits;
          k_nxt        = PROBE_RIGHT;
          state_nxt    = S_DONE;
          case (in_req)
            REQ_READ: state_nxt = S_RDCAP;
            REQ_STEP: begin
              if (!started_r) begin
                walker_row_nxt  = place_row;
                walker_col_nxt  = place_col;
                walker_head_nxt = place_head;
                started_nxt     = 1'b1;
              end else if (!at_goal) begin
                state_nxt = S_PROBE;
              end
            end
            default: ;
          endcase
        end
      end

      S_RDCAP: begin
        rw_nxt    = wall_q_r && in_store_r;
        rv_nxt    = vis_q_r && in_store_r;
        state_nxt = S_DONE;
      end

      S_PROBE: begin
        cand_row_nxt  = nbr_rsp.row;
        cand_col_nxt  = nbr_rsp.col;
        cand_head_nxt = nbr_rsp.heading;
        if (nbr_rsp.in_grid) begin
          state_nxt = S_PWAIT;
        end else if (k_r == PROBE_LEFT) begin
          walker_head_nxt = walker_head_r + TURN_BACK;
          state_nxt       = S_DONE;
        end else begin
          k_nxt = k_r + probe_t'(1);
        end
      end

      S_PWAIT: begin
        if (!wall_q_r) begin
          walker_row_nxt  = cand_row_r;
          walker_col_nxt  = cand_col_r;
          walker_head_nxt = cand_head_r;
          state_nxt       = S_DONE;
        end else if (k_r == PROBE_LEFT) begin
          walker_head_nxt = walker_head_r + TURN_BACK;
          state_nxt       = S_DONE;
        end else begin
          k_nxt     = k_r + probe_t'(1);
          state_nxt = S_PROBE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {7'd0, rv_r, rw_r, started_r && at_goal,
                           walker_head_r, walker_col_r, walker_row_r};
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_addr_r    <= '0;
      k_r           <= PROBE_RIGHT;
      walker_row_r  <= '0;
      walker_col_r  <= '0;
      walker_head_r <= HEAD_NORTH;
      started_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_addr_r    <= clr_addr_nxt;
      k_r           <= k_nxt;
      walker_row_r  <= walker_row_nxt;
      walker_col_r  <= walker_col_nxt;
      walker_head_r <= walker_head_nxt;
      started_r     <= started_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    cand_row_r  <= cand_row_nxt;
    cand_col_r  <= cand_col_nxt;
    cand_head_r <= cand_head_nxt;
    in_store_r  <= in_store_nxt;
    rw_r        <= rw_nxt;
    rv_r        <= rv_nxt;
    out_data_r  <= out_data_nxt;
  end

`ifndef SYNTHESIS
  // a result appears only right after the finishing state
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the finishing state");

  // the clearing sweep runs to its last cell without a break
  a_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR && clr_addr_r != LAST_ADDR) |=> (state_r == S_CLEAR))
    else $error("visited map clearing sweep cut short");

  // at most three probes per step
  a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE || state_r == S_PWAIT) |->
      (k_r == PROBE_RIGHT || k_r == PROBE_STRAIGHT || k_r == PROBE_LEFT))
    else $error("probe counter out of range");

  // a move after a probe goes to the probed candidate
  a_move_from_probe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PWAIT && !wall_q_r) |=>
      (walker_row_r == $past(cand_row_r) && walker_col_r == $past(cand_col_r)))
    else $error("walker move does not match probed cell");
`endif

endmodule

[sim/testbench.sv]
// testbench: self-checking bench for maze_wall_follower_core, a right-hand-rule grid walker
// holds its own walker model; depends on mwf_pkg and the core rtl only
`timescale 1ns / 1ps

module testbench;
  import mwf_pkg::*;

  // request kind the core ignores apart from reporting the walker
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
  localparam int GAP_MAX         = 14;
  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int DRAIN_CYCLES    = 24;
  localparam int RUN_LIMIT_NS    = 5_000_000;

  typedef struct {
    pos_t  row;
    pos_t  col;
    head_t heading;
    logic  arrived;
    logic  rd_wall;
    logic  rd_visited;
  } walker_report_t;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] reg_value;
    logic [REQ_W-1:0]      req;
    pos_t                  row;
    pos_t                  col;
    logic                  wall;
    bit                    typed;
    walker_report_t        want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic [IN_DATA_W-1:0]  in_tdata;   // cell_row[5:0], cell_col[11:6], is_wall[12], zero [15:13]
  logic [REQ_W-1:0]      in_tuser;   // req_type[1:0]
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // pos_row[5:0], pos_col[11:6], heading[13:12],
                                     // arrived[14], read_wall[15], read_visited[16]
  logic                  out_tvalid;
  logic                  out_tready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  cfg_valid;
  logic                  cfg_ready;

  maze_wall_follower_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
  );

  always #5 clk = ~clk;

  // walker model state, registers at their reset values
  logic wall_bits    [CELLS];
  bit   wall_known   [CELLS];
  bit   visited_bits [CELLS];
  int   loaded_cells [$];
  pos_t  walk_row    = '0;
  pos_t  walk_col    = '0;
  head_t walk_head   = HEAD_NORTH;
  bit    walk_placed = 1'b0;
  cnt_t  set_rows      = cnt_t'(MAX_ROWS);
  cnt_t  set_cols      = cnt_t'(MAX_COLS);
  pos_t  set_start_row = '0;
  pos_t  set_start_col = '0;
  pos_t  set_goal_row  = '0;
  pos_t  set_goal_col  = '0;

  walker_report_t report_q [$];
  walker_report_t blank_report;
  int fail_count     = 0;
  int items_sent     = 0;
  int steps_sent     = 0;
  int reports_seen   = 0;
  int arrivals_seen  = 0;
  bit no_gaps        = 1'b0;

  // rows or columns in use: zero acts as one, beyond storage saturates
  function automatic int grid_span(cnt_t c, int limit);
    if (c == '0) return 1;
    return (int'(c) > limit) ? limit : int'(c);
  endfunction

  function automatic bit cell_in_grid(int r, int c);
    return r >= 0 && c >= 0 && r < grid_span(set_rows, MAX_ROWS) &&
           c < grid_span(set_cols, MAX_COLS);
  endfunction

  function automatic int row_offset(head_t h);
    case (h)
      HEAD_NORTH: return -1;
      HEAD_SOUTH: return 1;
      default:    return 0;
    endcase
  endfunction

  function automatic int col_offset(head_t h);
    case (h)
      HEAD_EAST: return 1;
      HEAD_WEST: return -1;
      default:   return 0;
    endcase
  endfunction

  function automatic walker_report_t walker_state(int r, int c, head_t h, logic arr,
                                                  logic rw, logic rv);
    walker_report_t rep;
    rep.row        = pos_t'(r);
    rep.col        = pos_t'(c);
    rep.heading    = h;
    rep.arrived    = arr;
    rep.rd_wall    = rw;
    rep.rd_visited = rv;
    return rep;
  endfunction

  // advance the walker model by one item and return the report it gives
  function automatic walker_report_t predict_walk(logic [REQ_W-1:0] req, pos_t r, pos_t c,
                                                  logic w);
    walker_report_t rep;
    head_t probe_turns [3];
    head_t h;
    int addr, nr, nc, tr, tc, k;
    bit moved;
    probe_turns = '{TURN_RIGHT, TURN_NONE, TURN_LEFT};
    addr = int'(r) * MAX_COLS + int'(c);
    rep.rd_wall = 1'b0;
    rep.rd_visited = 1'b0;
    case (req)
      REQ_LOAD: begin
        wall_bits[addr] = w;
        if (!wall_known[addr]) begin
          wall_known[addr] = 1'b1;
          loaded_cells.push_back(addr);
        end
      end
      REQ_READ: begin
        rep.rd_wall    = wall_bits[addr];
        rep.rd_visited = visited_bits[addr];
      end
      REQ_STEP: begin
        if (!walk_placed) begin
          // placement: start clamped into the grid, heading from its border
          nr = grid_span(set_rows, MAX_ROWS);
          nc = grid_span(set_cols, MAX_COLS);
          walk_row = (int'(set_start_row) < nr) ? set_start_row : pos_t'(nr - 1);
          walk_col = (int'(set_start_col) < nc) ? set_start_col : pos_t'(nc - 1);
          if (walk_row == 0) walk_head = HEAD_SOUTH;
          else if (int'(walk_row) == nr - 1) walk_head = HEAD_NORTH;
          else if (walk_col == 0) walk_head = HEAD_EAST;
          else walk_head = HEAD_WEST;
          walk_placed = 1'b1;
        end else begin
          visited_bits[int'(walk_row) * MAX_COLS + int'(walk_col)] = 1'b1;
          if (!(walk_row == set_goal_row && walk_col == set_goal_col)) begin
            // right, straight, left, else turn back in place
            moved = 1'b0;
            for (k = 0; k < 3 && !moved; k++) begin
              h  = walk_head + probe_turns[k];
              tr = int'(walk_row) + row_offset(h);
              tc = int'(walk_col) + col_offset(h);
              if (cell_in_grid(tr, tc) && !wall_bits[tr * MAX_COLS + tc]) begin
                walk_row  = pos_t'(tr);
                walk_col  = pos_t'(tc);
                walk_head = h;
                moved     = 1'b1;
              end
            end
            if (!moved) walk_head = walk_head + TURN_BACK;
          end
        end
      end
      default: ;
    endcase
    rep.row     = walk_row;
    rep.col     = walk_col;
    rep.heading = walk_head;
    rep.arrived = walk_placed && walk_row == set_goal_row && walk_col == set_goal_col;
    return rep;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_ROW_COUNT: set_rows      = val;
      CFG_COL_COUNT: set_cols      = val;
      CFG_START_ROW: set_start_row = val[POS_W-1:0];
      CFG_START_COL: set_start_col = val[POS_W-1:0];
      CFG_GOAL_ROW:  set_goal_row  = val[POS_W-1:0];
      CFG_GOAL_COL:  set_goal_col  = val[POS_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  function automatic cnt_t pick_span();
    case ($urandom_range(0, 9))
      0:       return cnt_t'(0);
      1:       return cnt_t'(1);
      2:       return cnt_t'(MAX_ROWS);
      3:       return cnt_t'($urandom_range(MAX_ROWS + 1, 127));
      4:       return cnt_t'($urandom_range(7, MAX_ROWS - 1));
      default: return cnt_t'($urandom_range(2, 6));
    endcase
  endfunction

  function automatic plan_row_t item_row(logic [REQ_W-1:0] req, int r, int c, logic w,
                                         bit typed, walker_report_t want);
    plan_row_t pr;
    pr.is_cfg = 1'b0;
    pr.reg_index = '0;
    pr.reg_value = '0;
    pr.req = req;
    pr.row = pos_t'(r);
    pr.col = pos_t'(c);
    pr.wall = w;
    pr.typed = typed;
    pr.want = want;
    return pr;
  endfunction

  function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, int val);
    plan_row_t pr;
    pr = item_row(REQ_UNKNOWN, 0, 0, 1'b0, 1'b0, blank_report);
    pr.is_cfg = 1'b1;
    pr.reg_index = idx;
    pr.reg_value = CFG_DATA_W'(val);
    return pr;
  endfunction

  // one input transaction; the model advances when the core takes it
  task automatic send_item(input logic [REQ_W-1:0] req, input pos_t r, input pos_t c,
                           input logic w, input bit typed, input walker_report_t want);
    int gap;
    walker_report_t got;
    gap = draw_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = req;
    in_tdata  = {3'b000, w, c, r};
    do @(posedge clk); while (in_tready !== 1'b1);
    got = predict_walk(req, r, c, w);
    report_q.push_back(typed ? want : got);
    items_sent++;
    if (req == REQ_STEP) steps_sent++;
    @(negedge clk);
  endtask

  // load every unloaded in-grid neighbor so a step never probes an unwritten wall
  task automatic fill_neighbors();
    int d, tr, tc;
    if (walk_placed) begin
      for (d = 0; d < 4; d++) begin
        tr = int'(walk_row) + row_offset(head_t'(d));
        tc = int'(walk_col) + col_offset(head_t'(d));
        if (cell_in_grid(tr, tc) && !wall_known[tr * MAX_COLS + tc]) begin
          send_item(REQ_LOAD, pos_t'(tr), pos_t'(tc), $urandom_range(0, 2) == 0,
                    1'b0, blank_report);
        end
      end
    end
  endtask

  // wait until the core has handed back every pending result
  task automatic settle();
    in_tvalid = 1'b0;
    while (report_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    apply_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_report(input logic [OUT_DATA_W-1:0] seen);
    walker_report_t want;
    reports_seen++;
    if (report_q.size() == 0) begin
      $error("result %h arrived with nothing pending", seen);
      fail_count++;
      return;
    end
    want = report_q.pop_front();
    check_field("pos_row", 8'(want.row), 8'(seen[5:0]));
    check_field("pos_col", 8'(want.col), 8'(seen[11:6]));
    check_field("heading", 8'(want.heading), 8'(seen[13:12]));
    check_field("arrived", 8'(want.arrived), 8'(seen[14]));
    check_field("read_wall", 8'(want.rd_wall), 8'(seen[15]));
    check_field("read_visited", 8'(want.rd_visited), 8'(seen[16]));
    if (seen[14] === 1'b1) arrivals_seen++;
  endtask

  // result side: random stalls, sample at the edge, compare at the falling edge
  initial begin : result_monitor
    logic [OUT_DATA_W-1:0] seen;
    int stall;
    out_tready = 1'b0;
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      seen = out_tdata;
      @(negedge clk);
      check_report(seen);
    end
  end

  // overall run limit
  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    plan_row_t plan [$];
    walker_report_t at_origin;
    walker_report_t at_goal;
    cnt_t rows, cols;
    int p, n, pick, addr, goal_r, goal_c;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    blank_report = walker_state(0, 0, HEAD_NORTH, 1'b0, 1'b0, 1'b0);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part: unknown kind, field extremes, reads, clamped start, goal hold,
    // goal outside the grid
    at_origin = walker_state(0, 0, HEAD_NORTH, 1'b0, 1'b0, 1'b0);
    at_goal   = walker_state(4, 63, HEAD_NORTH, 1'b1, 1'b0, 1'b0);
    plan.push_back(item_row(REQ_UNKNOWN, 63, 63, 1'b1, 1'b1, at_origin));
    plan.push_back(item_row(REQ_LOAD, 0, 0, 1'b0, 1'b1, at_origin));
    plan.push_back(item_row(REQ_LOAD, 63, 63, 1'b1, 1'b1, at_origin));
    plan.push_back(item_row(REQ_LOAD, 4, 63, 1'b0, 1'b1, at_origin));
    plan.push_back(item_row(REQ_READ, 63, 63, 1'b0, 1'b1,
                            walker_state(0, 0, HEAD_NORTH, 1'b0, 1'b1, 1'b0)));
    plan.push_back(item_row(REQ_READ, 0, 0, 1'b1, 1'b1, at_origin));
    // five rows, column count saturating, start row past the last row
    plan.push_back(cfg_row(CFG_ROW_COUNT, 5));
    plan.push_back(cfg_row(CFG_COL_COUNT, 127));
    plan.push_back(cfg_row(CFG_START_ROW, 40));
    plan.push_back(cfg_row(CFG_START_COL, 63));
    plan.push_back(cfg_row(CFG_GOAL_ROW, 4));
    plan.push_back(cfg_row(CFG_GOAL_COL, 63));
    // placed on the last row facing north, already on the goal
    plan.push_back(item_row(REQ_STEP, 0, 0, 1'b0, 1'b1, at_goal));
    plan.push_back(item_row(REQ_STEP, 63, 63, 1'b1, 1'b1, at_goal));
    plan.push_back(item_row(REQ_READ, 4, 63, 1'b0, 1'b1,
                            walker_state(4, 63, HEAD_NORTH, 1'b1, 1'b0, 1'b1)));
    // goal moved outside the grid: walk on, never arriving
    plan.push_back(cfg_row(CFG_GOAL_ROW, 63));
    repeat (8) plan.push_back(item_row(REQ_STEP, 21, 42, 1'b1, 1'b0, blank_report));
    plan.push_back(item_row(REQ_UNKNOWN, 0, 0, 1'b0, 1'b0, blank_report));
    plan.push_back(item_row(REQ_READ, 63, 63, 1'b0, 1'b0, blank_report));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].reg_index, plan[i].reg_value);
        cfg_valid = 1'b0;
      end else begin
        if (plan[i].req == REQ_STEP) fill_neighbors();
        send_item(plan[i].req, plan[i].row, plan[i].col, plan[i].wall, plan[i].typed,
                  plan[i].want);
      end
    end

    // random phases, each with a fresh grid setting written while idle
    for (p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      no_gaps = ($urandom_range(0, 3) == 0);
      rows = pick_span();
      cols = pick_span();
      if (p == 0) rows = '0;
      if (p == 1) begin
        rows = cnt_t'(127);
        cols = cnt_t'(1);
      end
      if (p == 2) begin
        rows = cnt_t'(MAX_ROWS);
        cols = cnt_t'(MAX_COLS);
      end
      // mostly keep the walker inside the grid so it can keep moving
      if (p > 2 && $urandom_range(0, 3) != 0) begin
        if (grid_span(rows, MAX_ROWS) <= int'(walk_row)) rows = cnt_t'(walk_row) + cnt_t'(1);
        if (grid_span(cols, MAX_COLS) <= int'(walk_col)) cols = cnt_t'(walk_col) + cnt_t'(1);
      end
      if ($urandom_range(0, 3) != 0) begin
        goal_r = $urandom_range(0, grid_span(rows, MAX_ROWS) - 1);
        goal_c = $urandom_range(0, grid_span(cols, MAX_COLS) - 1);
      end else begin
        goal_r = $urandom_range(0, 63);
        goal_c = $urandom_range(0, 63);
      end
      if (p == 2) begin
        goal_r = 63;
        goal_c = 63;
      end
      write_reg(CFG_ROW_COUNT, rows);
      write_reg(CFG_COL_COUNT, cols);
      write_reg(CFG_START_ROW, (p == 2) ? 7'd63 : CFG_DATA_W'($urandom_range(0, 127)));
      write_reg(CFG_START_COL, (p == 2) ? 7'd127 : CFG_DATA_W'($urandom_range(0, 127)));
      // bit 6 of a position register is dropped by the core
      write_reg(CFG_GOAL_ROW, CFG_DATA_W'(goal_r + 64 * $urandom_range(0, 1)));
      write_reg(CFG_GOAL_COL, CFG_DATA_W'(goal_c + 64 * $urandom_range(0, 1)));
      cfg_valid = 1'b0;

      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 19);
        if (pick < 10) begin
          fill_neighbors();
          send_item(REQ_STEP, pos_t'($urandom), pos_t'($urandom), 1'($urandom_range(0, 1)),
                    1'b0, blank_report);
        end else if (pick == 14) begin
          send_item(REQ_LOAD, pos_t'($urandom), pos_t'($urandom), 1'($urandom_range(0, 1)),
                    1'b0, blank_report);
        end else if (pick < 15 || loaded_cells.size() == 0) begin
          send_item(REQ_LOAD, pos_t'($urandom_range(0, grid_span(set_rows, MAX_ROWS) - 1)),
                    pos_t'($urandom_range(0, grid_span(set_cols, MAX_COLS) - 1)),
                    $urandom_range(0, 2) == 0, 1'b0, blank_report);
        end else if (pick < 19) begin
          // reads only touch cells that have been loaded
          addr = loaded_cells[$urandom_range(0, loaded_cells.size() - 1)];
          send_item(REQ_READ, pos_t'(addr / MAX_COLS), pos_t'(addr % MAX_COLS),
                    1'($urandom_range(0, 1)), 1'b0, blank_report);
        end else begin
          send_item(REQ_UNKNOWN, pos_t'($urandom), pos_t'($urandom), 1'($urandom_range(0, 1)),
                    1'b0, blank_report);
        end
      end
    end

    // drain and watch for stray results
    settle();
    no_gaps = 1'b0;
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("walker run: %0d items incl. %0d steps over %0d grid settings",
             items_sent, steps_sent, RANDOM_PHASES + 1);
    $display("results checked: %0d, reports on goal: %0d, mismatches: %0d",
             reports_seen, arrivals_seen, fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
